[design/utu_pkg.sv]
package utu_pkg;

  localparam int UNIT_W = 21;

  localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
  localparam logic [UNIT_W-1:0] MAX_CODE_POINT   = 21'h10FFFF;
  localparam logic [UNIT_W-1:0] SURR_LOW_BOUND   = 21'h00D800;
  localparam logic [UNIT_W-1:0] SURR_HIGH_BOUND  = 21'h00DFFF;
  localparam logic [UNIT_W-1:0] TRAIL_SURR_BASE  = 21'h00DC00;
  localparam logic [UNIT_W-1:0] PLANE1_BASE      = 21'h010000;
  localparam logic [UNIT_W-1:0] MIN_TWO_BYTE     = 21'h000080;
  localparam logic [UNIT_W-1:0] MIN_THREE_BYTE   = 21'h000800;

  localparam logic SURROGATE_MODE_RESET = 1'b1;

  // Register index of surrogate_mode in the configuration map
  localparam logic REG_SURROGATE_MODE = 1'b0;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_of_run;
    logic              string_done;
  } unit_t;

  // Results of one byte: zero, one or two units
  typedef struct packed {
    logic [1:0] count;
    unit_t      u0;
    unit_t      u1;
  } dec_result_t;

endpackage

[design/utu_decoder.sv]
module utu_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                surrogate_mode,
  input  logic [7:0]          in_byte,
  input  logic                end_of_string,
  output utu_pkg::dec_result_t result
);
  import utu_pkg::*;

  logic [UNIT_W-1:0] partial_value, partial_value_next;
  logic [1:0]        bytes_still_due, bytes_still_due_next;
  logic [1:0]        sequence_length, sequence_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_still_due <= '0;
      sequence_length <= '0;
    end else if (advance) begin
      partial_value   <= partial_value_next;
      bytes_still_due <= bytes_still_due_next;
      sequence_length <= sequence_length_next;
    end
  end

  // Lead byte classification
  logic              lead2, lead3, lead4, lead_open;
  logic [UNIT_W-1:0] lead_unit, lead_pv;
  logic [1:0]        lead_due;

  always_comb begin
    lead2     = (in_byte[7:5] == 3'b110);
    lead3     = (in_byte[7:4] == 4'b1110);
    lead4     = (in_byte[7:3] == 5'b11110);
    lead_open = lead2 | lead3 | lead4;
    lead_unit = in_byte[7] ? REPLACEMENT_CHAR : {13'b0, in_byte};
    if (lead2) begin
      lead_pv  = {16'b0, in_byte[4:0]};
      lead_due = 2'd1;
    end else if (lead3) begin
      lead_pv  = {17'b0, in_byte[3:0]};
      lead_due = 2'd2;
    end else begin
      lead_pv  = {18'b0, in_byte[2:0]};
      lead_due = 2'd3;
    end
  end

  // Completion check on the gathered value
  logic              is_cont;
  logic [UNIT_W-1:0] acc, min_val, cp;
  logic [19:0]       plane_off;

  always_comb begin
    is_cont = (in_byte[7:6] == 2'b10);
    acc     = {partial_value[UNIT_W-7:0], in_byte[5:0]};
    case (sequence_length)
      2'd1:    min_val = MIN_TWO_BYTE;
      2'd2:    min_val = MIN_THREE_BYTE;
      default: min_val = PLANE1_BASE;
    endcase
    if (acc < min_val || acc > MAX_CODE_POINT ||
        (acc >= SURR_LOW_BOUND && acc <= SURR_HIGH_BOUND)) begin
      cp = REPLACEMENT_CHAR;
    end else begin
      cp = acc;
    end
    plane_off = 20'(cp - PLANE1_BASE);
  end

  logic [1:0]        n;
  logic [UNIT_W-1:0] ua, ub;

  always_comb begin
    n  = 2'd0;
    ua = '0;
    ub = '0;
    partial_value_next   = partial_value;
    bytes_still_due_next = bytes_still_due;
    sequence_length_next = sequence_length;

    if (bytes_still_due == 2'd0) begin
      if (lead_open) begin
        partial_value_next   = lead_pv;
        bytes_still_due_next = lead_due;
        sequence_length_next = lead_due;
      end else begin
        ua = lead_unit;
        n  = 2'd1;
      end
    end else if (is_cont) begin
      partial_value_next   = acc;
      bytes_still_due_next = bytes_still_due - 2'd1;
      if (bytes_still_due == 2'd1) begin
        if (surrogate_mode && cp >= PLANE1_BASE) begin
          ua = SURR_LOW_BOUND + {11'b0, plane_off[19:10]};
          ub = TRAIL_SURR_BASE + {11'b0, plane_off[9:0]};
          n  = 2'd2;
        end else begin
          ua = cp;
          n  = 2'd1;
        end
        partial_value_next   = '0;
        sequence_length_next = '0;
      end
    end else begin
      // Bad continuation: replace, then take the byte again as a lead
      ua = REPLACEMENT_CHAR;
      n  = 2'd1;
      partial_value_next   = '0;
      bytes_still_due_next = '0;
      sequence_length_next = '0;
      if (lead_open) begin
        partial_value_next   = lead_pv;
        bytes_still_due_next = lead_due;
        sequence_length_next = lead_due;
      end else begin
        ub = lead_unit;
        n  = 2'd2;
      end
    end

    if (end_of_string) begin
      if (bytes_still_due_next != 2'd0) begin
        if (n == 2'd0) begin
          ua = REPLACEMENT_CHAR;
        end else begin
          ub = REPLACEMENT_CHAR;
        end
        n = n + 2'd1;
      end
      partial_value_next   = '0;
      bytes_still_due_next = '0;
      sequence_length_next = '0;
    end

    result.count          = n;
    result.u0.code_unit   = ua;
    result.u0.last_of_run = (n == 2'd1);
    result.u0.string_done = (n == 2'd1) && end_of_string;
    result.u1.code_unit   = ub;
    result.u1.last_of_run = 1'b1;
    result.u1.string_done = end_of_string;
  end

endmodule

[design/utu_out_buf.sv]
module utu_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utu_pkg::dec_result_t result,
  output logic [1:0]          room,
  output logic                out_valid,
  input  logic                out_ready,
  output utu_pkg::unit_t      head
);
  import utu_pkg::*;

  unit_t      slot0, slot0_next;
  unit_t      slot1, slot1_next;
  logic [1:0] cnt, cnt_next;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign head      = slot0;
  assign pop       = out_valid && out_ready;
  assign room      = 2'd2 - cnt + {1'b0, pop};

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    cnt_next   = cnt;
    if (pop) begin
      slot0_next = slot1;
      cnt_next   = cnt_next - 2'd1;
    end
    if (push && result.count != 2'd0) begin
      if (cnt_next == 2'd0) begin
        slot0_next = result.u0;
      end else begin
        slot1_next = result.u0;
      end
      cnt_next = cnt_next + 2'd1;
      if (result.count == 2'd2) begin
        // only pushed into an empty buffer
        slot1_next = result.u1;
        cnt_next   = cnt_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

[design/utu_apb_regs.sv]
module utu_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        surrogate_mode
);
  import utu_pkg::*;

  logic hit;

  assign hit = (paddr[2] == REG_SURROGATE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      surrogate_mode <= SURROGATE_MODE_RESET;
    end else if (psel && penable && pwrite && hit) begin
      surrogate_mode <= pwdata[0];
    end
  end

  assign prdata = hit ? {31'b0, surrogate_mode} : '0;

endmodule

[design/utf8_to_utf16_transcoder_core.sv]
// UTF-8 to UTF-16/UTF-32 stream decoder. Feed one source byte per transfer on
// the input channel, with end_of_string on the final byte of a string; wide
// code units come out on the output channel, with last_of_run on the last
// unit caused by a byte and string_done on the final unit of the string.
// surrogate_mode (APB offset 0x0, reset 1) selects UTF-16 with surrogate pairs
// (1) or UTF-32 code points (0); change it only while the block is idle.
// Malformed input (bad lead, bad continuation, overlong, surrogate or
// out-of-range value, sequence cut short at end of string) yields U+FFFD.
// Rate: one byte per cycle when the output side keeps up. A byte that yields
// two units (surrogate pair, or a bad continuation followed by a unit of its
// own) puts the extra unit in the second entry of the two-entry output
// buffer, and a held byte stalls whenever the buffer lacks room for all of
// its units, so such a byte can slow the input unless a byte with no units
// (a lead) lets the buffer drain first. in_ready follows that room. A byte
// passes the input register and then the output buffer before its first
// unit comes out.
module utf8_to_utf16_transcoder_core (
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  // unit stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_unit,
  output logic        last_of_run,
  output logic        string_done,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utu_pkg::*;

  logic        surrogate_mode;
  logic        in_full;
  logic [7:0]  byte_q;
  logic        eos_q;
  logic        advance;
  logic [1:0]  room;
  dec_result_t result;
  unit_t       head;

  assign pready = 1'b1;

  utu_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .surrogate_mode (surrogate_mode)
  );

  // Retire the held byte once the output buffer has room for all its units;
  // a byte with no units retires at once.
  assign advance  = in_full && (room >= result.count);
  assign in_ready = !in_full || advance;

  // Input register: take a new byte when none is held or the held one retires
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
      eos_q  <= end_of_string;
    end
  end

  // Decode the held byte against the open sequence state
  utu_decoder u_dec (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .surrogate_mode (surrogate_mode),
    .in_byte        (byte_q),
    .end_of_string  (eos_q),
    .result         (result)
  );

  // Result register: two-entry queue so a pair of units does not drop data
  utu_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .result    (result),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign code_unit   = head.code_unit;
  assign last_of_run = head.last_of_run;
  assign string_done = head.string_done;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Stream check of the UTF-8 to UTF-16/UTF-32 decoder.
// Bytes go in through send_byte, which also runs the local decoder on every
// accepted transfer and queues the units that the block must produce. The
// unit checker pops one expectation per output transfer and compares all
// three fields. Tests run in turn from one initial block:
//   - directed strings: extremes, every sequence length, each error form
//   - register access: unmapped write, upper data bits, readback, UTF-32 path
//   - three random phases with different idling on each side and both modes
module tb_top;
  import utu_pkg::*;

  localparam logic MODE_UTF32      = 1'b0;
  localparam logic MODE_UTF16      = 1'b1;
  localparam int   UNMAPPED_REG    = 1;
  localparam int   STALL_LIMIT     = 2000;  // cycles with no transfer at all
  localparam int   SETTLE_CYCLES   = 8;     // idle time after the last unit comes out
  localparam int   ITEMS_PER_PHASE = 460;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_unit;
  logic        last_of_run;
  logic        string_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Local decoder state, mirrors what the block holds between bytes
  logic        mode_utf16 = SURROGATE_MODE_RESET;
  logic [20:0] acc_bits = '0;     // payload gathered so far
  logic [1:0]  cont_left = '0;    // continuation bytes still due, 0 = idle
  logic [1:0]  cont_total = '0;   // continuation count of the open sequence

  logic [20:0] byte_units[$];     // units of the byte being decoded
  unit_t       pending_units[$];  // units the block still owes us

  int sender_idle_pct = 0;
  int sink_idle_pct = 0;
  int bytes_sent = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  utf8_to_utf16_transcoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_unit    (code_unit),
    .last_of_run  (last_of_run),
    .string_done  (string_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Local decoder
  // ---------------------------------------------------------------------

  // Decode a byte seen with no sequence open: ASCII goes straight out,
  // a valid lead opens a sequence, anything else is a bad lead.
  task automatic open_sequence(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      byte_units.push_back({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      acc_bits = 21'(b[4:0]);
      cont_left = 2'd1;
      cont_total = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_bits = 21'(b[3:0]);
      cont_left = 2'd2;
      cont_total = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      acc_bits = 21'(b[2:0]);
      cont_left = 2'd3;
      cont_total = 2'd3;
    end else begin
      byte_units.push_back(REPLACEMENT_CHAR);
    end
  endtask

  // Split into a surrogate pair only in UTF-16 mode and above the BMP
  task automatic emit_code_point(input logic [20:0] cp);
    logic [20:0] offs;
    if (mode_utf16 && cp >= PLANE1_BASE) begin
      offs = cp - PLANE1_BASE;
      byte_units.push_back(SURR_LOW_BOUND + 21'(offs[19:10]));
      byte_units.push_back(TRAIL_SURR_BASE + 21'(offs[9:0]));
    end else begin
      byte_units.push_back(cp);
    end
  endtask

  // Work out every unit one accepted byte causes and queue them in order
  task automatic decode_utf8_byte(input logic [7:0] b, input logic eos);
    logic [20:0] cp;
    logic [20:0] floor_val;
    unit_t       u;
    if (cont_left == 2'd0) begin
      open_sequence(b);
    end else if (b[7:6] == 2'b10) begin
      acc_bits = (acc_bits << 6) | 21'(b[5:0]);
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        case (cont_total)
          2'd1:    floor_val = MIN_TWO_BYTE;
          2'd2:    floor_val = MIN_THREE_BYTE;
          default: floor_val = PLANE1_BASE;
        endcase
        cp = acc_bits;
        // Overlong, out of range or a surrogate value all become U+FFFD
        if (cp < floor_val || cp > MAX_CODE_POINT ||
            (cp >= SURR_LOW_BOUND && cp <= SURR_HIGH_BOUND))
          cp = REPLACEMENT_CHAR;
        emit_code_point(cp);
        acc_bits = '0;
        cont_total = '0;
      end
    end else begin
      // Bad continuation: replace, drop the sequence, then retry as a lead
      byte_units.push_back(REPLACEMENT_CHAR);
      acc_bits = '0;
      cont_left = '0;
      cont_total = '0;
      open_sequence(b);
    end
    if (eos) begin
      // A string that ends inside a sequence owes one more replacement
      if (cont_left != 2'd0)
        byte_units.push_back(REPLACEMENT_CHAR);
      acc_bits = '0;
      cont_left = '0;
      cont_total = '0;
    end
    foreach (byte_units[i]) begin
      u.code_unit = byte_units[i];
      u.last_of_run = (i == byte_units.size() - 1);
      u.string_done = u.last_of_run && eos;
      pending_units.push_back(u);
    end
    byte_units.delete();
  endtask

  // ---------------------------------------------------------------------
  // Stream driving
  // ---------------------------------------------------------------------

  // Present one byte and hold it until the transfer happens. Valid stays
  // high on return so that back-to-back bytes never drop it for a step.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    decode_utf8_byte(b, eos);
    bytes_sent++;
  endtask

  // Send n bytes packed MSB first; eos_last tags the final one
  task automatic send_seq(input logic [31:0] bytes, input int n, input logic eos_last);
    for (int i = n - 1; i >= 0; i--)
      send_byte(bytes[8*i +: 8], eos_last && i == 0);
  endtask

  // Drop valid and hold off until every queued unit has come out
  task automatic wait_until_drained(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_units.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // One random character: mostly well-formed UTF-8 with random content,
  // some with raw payload bits (overlong, surrogate, above range), some cut
  // short, and some plain noise bytes.
  task automatic send_random_char();
    logic [7:0]  seq [4];
    logic [20:0] cp;
    int          len;
    int          keep;
    int          pick;
    logic        eos;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
    end else begin
      len = $urandom_range(1, 4);
      if ($urandom_range(4) == 0) begin
        cp = 21'($urandom);
      end else begin
        case (len)
          1:       cp = 21'($urandom_range(0, 32'h7F));
          2:       cp = 21'($urandom_range(32'h80, 32'h7FF));
          3:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
          default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
      end
      case (len)
        1: seq[0] = {1'b0, cp[6:0]};
        2: begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
        end
        3: begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
        end
        default: begin
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
        end
      endcase
      keep = len;
      if (pick < 22 && len > 1)
        keep = $urandom_range(1, len - 1);
      eos = ($urandom_range(9) == 0) || (keep < len && $urandom_range(1) == 1);
      for (int i = 0; i < keep; i++)
        send_byte(seq[i], eos && i == keep - 1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------

  task automatic write_reg(input int idx, input logic [31:0] value);
    paddr <= 3'(4 * idx);
    pwdata <= value;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SURROGATE_MODE)
      mode_utf16 = value[0];
    @(posedge clk);
  endtask

  task automatic check_mode_readback();
    paddr <= 3'(4 * REG_SURROGATE_MODE);
    pwrite <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== mode_utf16) begin
      mismatch_count++;
      $display("%0t: surrogate_mode readback expected %b actual %b",
               $time, mode_utf16, prdata[0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed_decoding();
    send_seq(32'h00, 1, 1'b0);            // smallest byte
    send_seq(32'h7F, 1, 1'b1);            // top of ASCII, string ends on it
    send_seq(32'hC280, 2, 1'b0);          // smallest two-byte value
    send_seq(32'hF0908080, 4, 1'b1);      // first pair, string ends on it
    send_seq(32'hF48FBFBF, 4, 1'b0);      // largest code point
    send_seq(32'hC080, 2, 1'b0);          // overlong form
    send_seq(32'hEDA080, 3, 1'b0);        // encoded surrogate
    send_seq(32'hF4908080, 4, 1'b0);      // above the code point range
    send_seq(32'h80, 1, 1'b0);            // stray continuation as lead
    send_seq(32'hFF, 1, 1'b0);            // largest byte, bad lead
    send_seq(32'hE2C380, 3, 1'b0);        // bad continuation, then new lead
    send_seq(32'hF09F, 2, 1'b1);          // string cut short
  endtask

  task automatic test_mode_register();
    wait_until_drained(SETTLE_CYCLES);
    // An unmapped register must leave the mode alone
    write_reg(UNMAPPED_REG, 32'h0000_0000);
    check_mode_readback();
    // Only bit 0 counts: upper bits set, bit 0 clear selects UTF-32
    write_reg(REG_SURROGATE_MODE, 32'hFFFF_FFFE);
    check_mode_readback();
    send_seq(32'hF09F9880, 4, 1'b1);      // one wide code point, no pair
    send_seq(32'hF48FBFBF, 4, 1'b1);
  endtask

  task automatic test_random_stream(input int src_pct, input int snk_pct,
                                    input logic mode, input int n_items,
                                    input bit hold_midway);
    int target;
    bit held;
    wait_until_drained(SETTLE_CYCLES);
    write_reg(REG_SURROGATE_MODE, {31'd0, mode});
    check_mode_readback();
    sender_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    target = bytes_sent + n_items;
    held = 1'b0;
    while (bytes_sent < target) begin
      // Once per phase if asked: stop sending until the output runs dry
      if (hold_midway && !held && bytes_sent > target - n_items / 2) begin
        wait_until_drained(0);
        held = 1'b1;
      end
      send_random_char();
    end
    // Close the string so the next phase starts from idle
    send_byte(8'h0A, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Output ready, unit checker, watchdog
  // ---------------------------------------------------------------------

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= sink_idle_pct);

  // Compare every output transfer against the oldest queued unit
  always @(posedge clk) begin
    unit_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        mismatch_count++;
        $display("%0t: unit/last/done expected none actual %h/%b/%b",
                 $time, code_unit, last_of_run, string_done);
      end else begin
        want = pending_units.pop_front();
        if (want.code_unit !== code_unit || want.last_of_run !== last_of_run ||
            want.string_done !== string_done) begin
          mismatch_count++;
          $display("%0t: unit/last/done expected %h/%b/%b actual %h/%b/%b",
                   $time, want.code_unit, want.last_of_run, want.string_done,
                   code_unit, last_of_run, string_done);
        end
      end
    end
  end

  // Count cycles in which no transfer happens on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("utf8_to_utf16_transcoder_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_decoding();
    test_mode_register();
    test_random_stream(28, 70, MODE_UTF16, ITEMS_PER_PHASE, 1'b0);
    test_random_stream(70, 28, MODE_UTF32, ITEMS_PER_PHASE, 1'b0);
    test_random_stream(0, 0, MODE_UTF16, ITEMS_PER_PHASE, 1'b1);
    wait_until_drained(SETTLE_CYCLES + 2);
    if (mismatch_count == 0)
      $display("utf8_to_utf16_transcoder_core test passed");
    else
      $display("utf8_to_utf16_transcoder_core test failed");
    $finish;
  end

endmodule

[utf8_to_utf16_transcoder_core.f]
design/utu_pkg.sv
design/utu_decoder.sv
design/utu_out_buf.sv
design/utu_apb_regs.sv
design/utf8_to_utf16_transcoder_core.sv
tb/tb_top.sv
